### rtl/core/lzssed_pkg.sv
// Shared types and constants of the LZSS entry decompressor.
package lzssed_pkg;

    localparam int          LEN_W    = 24;
    localparam int          WIN_AW   = 12;
    localparam int          WIN_SIZE = 4096;
    localparam int          MIN_COPY = 3;
    localparam logic [7:0]  LZ_MODE  = 8'h20;

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_LIT  = 2'd1,
        CMD_RAW  = 2'd2,
        CMD_COPY = 2'd3
    } cmd_kind_t;

    // arg: header length, literal or raw byte in [7:0], or match word in [15:0]
    typedef struct packed {
        cmd_kind_t         kind;
        logic [LEN_W-1:0]  arg;
    } cmd_t;

endpackage

### rtl/core/lzssed_front.sv
// Front end: accepts entry bytes, parses header and tokens, issues commands.
module lzssed_front
    import lzssed_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // entry_end
    output logic        push_valid,
    output cmd_t        push_cmd,
    input  logic        push_ready
);

    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_CONTROL  = 5'b00010,
        PH_TOKEN    = 5'b00100,
        PH_MATCH_HI = 5'b01000,
        PH_RAW      = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        hcnt_reg, hcnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        ctrl_reg, ctrl_next;
    logic [3:0]        tok_reg, tok_next;
    logic [7:0]        mlow_reg, mlow_next;
    logic [3:0]        tok_dec;
    logic              accept;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign tok_dec  = (tok_reg != 4'd0) ? tok_reg - 4'd1 : 4'd0;

    always_comb begin
        phase_next    = phase_reg;
        hcnt_next     = hcnt_reg;
        len_next      = len_reg;
        ctrl_next     = ctrl_reg;
        tok_next      = tok_reg;
        mlow_next     = mlow_reg;
        push_valid    = 1'b0;
        push_cmd.kind = CMD_HDR;
        push_cmd.arg  = '0;
        if (accept) begin
            case (phase_reg)
                PH_CONTROL: begin
                    ctrl_next  = s_tdata;
                    tok_next   = 4'd8;
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (ctrl_reg[0]) begin
                        push_valid    = 1'b1;
                        push_cmd.kind = CMD_LIT;
                        push_cmd.arg  = {16'd0, s_tdata};
                        ctrl_next     = ctrl_reg >> 1;
                        tok_next      = tok_dec;
                        phase_next    = (tok_dec != 4'd0) ? PH_TOKEN : PH_CONTROL;
                    end else begin
                        mlow_next  = s_tdata;
                        phase_next = PH_MATCH_HI;
                    end
                end
                PH_MATCH_HI: begin
                    push_valid    = 1'b1;
                    push_cmd.kind = CMD_COPY;
                    push_cmd.arg  = {8'd0, s_tdata, mlow_reg};
                    ctrl_next     = ctrl_reg >> 1;
                    tok_next      = tok_dec;
                    phase_next    = (tok_dec != 4'd0) ? PH_TOKEN : PH_CONTROL;
                end
                PH_RAW: begin
                    push_valid    = 1'b1;
                    push_cmd.kind = CMD_RAW;
                    push_cmd.arg  = {16'd0, s_tdata};
                end
                default: begin
                    phase_next = PH_HEADER;
                    case (hcnt_reg)
                        2'd0: begin
                            len_next  = {16'd0, s_tdata};
                            hcnt_next = 2'd1;
                        end
                        2'd1: begin
                            len_next[15:8] = s_tdata;
                            hcnt_next      = 2'd2;
                        end
                        2'd2: begin
                            len_next[23:16] = s_tdata;
                            hcnt_next       = 2'd3;
                        end
                        default: begin
                            push_valid    = 1'b1;
                            push_cmd.kind = CMD_HDR;
                            push_cmd.arg  = len_reg;
                            ctrl_next     = 8'd0;
                            tok_next      = 4'd0;
                            hcnt_next     = 2'd0;
                            phase_next    = (s_tdata == LZ_MODE) ? PH_CONTROL : PH_RAW;
                        end
                    endcase
                end
            endcase
            if (s_tlast) begin
                phase_next = PH_HEADER;
                hcnt_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= 2'd0;
            len_reg   <= '0;
            ctrl_reg  <= 8'd0;
            tok_reg   <= 4'd0;
            mlow_reg  <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            len_reg   <= len_next;
            ctrl_reg  <= ctrl_next;
            tok_reg   <= tok_next;
            mlow_reg  <= mlow_next;
        end
    end

endmodule

### rtl/core/lzssed_cmd_fifo.sv
// Command queue between the parsing front end and the window back end.
module lzssed_cmd_fifo
    import lzssed_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  cmd_t  push_cmd,
    output logic  pop_valid,
    input  logic  pop_ready,
    output cmd_t  pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/lzssed_back.sv
// Back end: history window, copy sequencer, length limit and output register.
module lzssed_back
    import lzssed_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  cmd_t         pop_cmd,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [7:0] out_byte, [31:8] decoded_length
    output logic         m_tlast,   // run_last
    output logic         m_tuser    // entry_last
);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_READ  = 3'b010,
        BK_WRITE = 3'b100
    } bk_state_t;

    logic [7:0]         win_mem [WIN_SIZE];

    bk_state_t          state_reg, state_next;
    logic [WIN_AW-1:0]  wpos_reg, wpos_next;
    logic               wrap_reg, wrap_next;
    logic [WIN_AW-1:0]  src_reg, src_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [7:0]         rd_data_reg;
    logic               rd_hit_reg;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg;
    logic [LEN_W-1:0]   m_len_reg;
    logic               m_last_reg, m_entry_reg;

    logic               out_free;
    logic               we;
    logic [7:0]         wdata;
    logic               emit_req, emit, run_end;
    logic [7:0]         emit_byte;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = emit_req && (remain_reg != '0);

    always_comb begin
        state_next  = state_reg;
        wpos_next   = wpos_reg;
        wrap_next   = wrap_reg;
        src_next    = src_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        remain_next = remain_reg;
        pop_ready   = 1'b0;
        we          = 1'b0;
        wdata       = 8'd0;
        emit_req    = 1'b0;
        emit_byte   = 8'd0;
        run_end     = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    case (pop_cmd.kind)
                        CMD_HDR: begin
                            pop_ready   = 1'b1;
                            wpos_next   = '0;
                            wrap_next   = 1'b0;
                            total_next  = pop_cmd.arg;
                            remain_next = pop_cmd.arg;
                        end
                        CMD_LIT: begin
                            if (out_free) begin
                                pop_ready = 1'b1;
                                we        = 1'b1;
                                wdata     = pop_cmd.arg[7:0];
                                emit_req  = 1'b1;
                                emit_byte = pop_cmd.arg[7:0];
                                run_end   = 1'b1;
                            end
                        end
                        CMD_RAW: begin
                            if (out_free) begin
                                pop_ready = 1'b1;
                                emit_req  = 1'b1;
                                emit_byte = pop_cmd.arg[7:0];
                                run_end   = 1'b1;
                            end
                        end
                        CMD_COPY: begin
                            pop_ready  = 1'b1;
                            src_next   = pop_cmd.arg[WIN_AW-1:0];
                            cnt_next   = {1'b0, pop_cmd.arg[15:12]} + 5'(MIN_COPY - 1);
                            state_next = BK_READ;
                        end
                        default: begin
                            pop_ready = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                state_next = BK_WRITE;
            end
            BK_WRITE: begin
                if (out_free) begin
                    we         = 1'b1;
                    wdata      = rd_hit_reg ? rd_data_reg : 8'd0;
                    emit_req   = 1'b1;
                    emit_byte  = wdata;
                    run_end    = (cnt_reg == 5'd0);
                    src_next   = src_reg + 1'b1;
                    cnt_next   = cnt_reg - 5'd1;
                    state_next = (cnt_reg == 5'd0) ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
        if (we) begin
            wpos_next = wpos_reg + 1'b1;
            if (wpos_reg == '1) begin
                wrap_next = 1'b1;
            end
        end
        if (emit) begin
            remain_next = remain_reg - 1'b1;
        end
        m_valid_next = out_free ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            win_mem[wpos_reg] <= wdata;
        end
        rd_data_reg <= win_mem[src_reg];
        rd_hit_reg  <= wrap_reg || (src_reg < wpos_reg);
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg  <= emit_byte;
            m_len_reg   <= total_reg;
            m_last_reg  <= run_end || (remain_reg == LEN_W'(1));
            m_entry_reg <= (remain_reg == LEN_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            wpos_reg    <= '0;
            wrap_reg    <= 1'b0;
            src_reg     <= '0;
            cnt_reg     <= 5'd0;
            total_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            wrap_reg    <= wrap_next;
            src_reg     <= src_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_len_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_entry_reg;

endmodule

### rtl/core/lzss_entry_decompressor.sv
// Top level of the LZSS entry decompressor.
// Takes one archive entry byte per transfer: a 4-byte header (24-bit length, mode byte),
// then LZSS tokens for mode 0x20 or raw bytes otherwise, and emits decoded bytes up to
// the header length. The front end takes one byte per cycle while the command queue
// has room. In the back end a header, literal or raw byte is handled from the idle
// state, and each byte of a match word passes through a read and a write-back state,
// as the 4096-byte window is read through a register. The window needs no clearing
// pass: a fill mark treats bytes not yet written in the current entry as zero.
module lzss_entry_decompressor
    import lzssed_pkg::*;
#(
    parameter int CMD_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // entry_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [7:0] out_byte, [31:8] decoded_length
    output logic         m_tlast,   // run_last
    output logic         m_tuser    // entry_last
);

    logic  push_valid, push_ready, pop_valid, pop_ready;
    cmd_t  push_cmd, pop_cmd;

    lzssed_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    lzssed_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lzssed_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/core/lzssed_checker.sv
// Port-level assertions for the LZSS entry decompressor and their bind.
module lzssed_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result transfer changed");

    a_entry_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("entry end not marked as end of run");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:8] != 24'd0)
        else $error("result emitted for a zero-length entry");

endmodule

bind lzss_entry_decompressor lzssed_checker u_checker (.*);
